FILE: src/dq_pkg.sv
// dq_pkg: shared constants and controller/datapath interface types
// for the double-ended queue. Depends on nothing.
package dq_pkg;

    localparam int DEPTH_DEFAULT = 64;

    // operation codes carried by func
    localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
    localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [2:0] FUNC_REMOVE     = 3'd4;
    localparam logic [2:0] FUNC_CLEAR      = 3'd5;

    // result status codes
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic rm_read;
        logic rm_write;
        logic load;
    } dq_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_remove;
        logic is_empty;
        logic walk_last;
        logic out_free;
    } dq_stat_t;

endpackage

FILE: src/dq_datapath.sv
// dq_datapath: ring buffer storage, head and count registers, removal walk
// and the result register. Depends on dq_pkg; driven by dq_ctrl commands.
module dq_datapath
    import dq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dq_cmd_t              cmd,
    output dq_stat_t             stat,
    input  logic [2:0]           func,
    input  logic signed [31:0]   value,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [1:0]           status,
    output logic [CW-1:0]        entry_count,
    output logic signed [31:0]   front_value,
    output logic signed [31:0]   back_value,
    output logic [CW-1:0]        removed_count
);

    localparam logic [CW:0]   DEPTH_W  = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    // ring position of an offset from the head, wrap by one compare-subtract
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW + 1)'(base) + (CW + 1)'(off);
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    logic [31:0] mem [DEPTH];

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] kept_reg, kept_next;
    logic [2:0]    func_reg, func_next;
    logic [31:0]   val_reg, val_next;
    logic [1:0]    code_reg, code_next;
    logic [CW-1:0] removed_reg, removed_next;

    logic          out_valid_reg, out_valid_next;
    logic [1:0]    out_status_reg, out_status_next;
    logic [CW-1:0] out_count_reg, out_count_next;
    logic [31:0]   out_front_reg, out_front_next;
    logic [31:0]   out_back_reg, out_back_next;
    logic [CW-1:0] out_removed_reg, out_removed_next;

    logic [31:0]   rd_a_reg, rd_b_reg;
    logic [AW-1:0] raddr_a, raddr_b;
    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;

    logic [AW-1:0] head_inc, head_dec;
    logic [CW-1:0] idx_inc;
    logic          full, empty;

    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign idx_inc  = idx_reg + 1'b1;
    assign full     = (count_reg == DEPTH_C);
    assign empty    = (count_reg == '0);

    // read addresses: walk entry while removing, otherwise front and back
    assign raddr_a = cmd.rm_read ? slot(head_reg, idx_reg) : head_reg;
    assign raddr_b = slot(head_reg, count_reg - 1'b1);

    // status back to the controller
    assign stat.is_remove = (func_reg == FUNC_REMOVE);
    assign stat.is_empty  = empty;
    assign stat.walk_last = (idx_inc == count_reg);
    assign stat.out_free  = !out_valid_reg || out_ready;

    // next-state logic for the queue and the result register
    always_comb
    begin
        logic [CW-1:0] kept_n;
        kept_n           = kept_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        kept_next        = kept_reg;
        func_next        = func_reg;
        val_next         = val_reg;
        code_next        = code_reg;
        removed_next     = removed_reg;
        we               = 1'b0;
        waddr            = slot(head_reg, count_reg);
        wdata            = val_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_status_next  = out_status_reg;
        out_count_next   = out_count_reg;
        out_front_next   = out_front_reg;
        out_back_next    = out_back_reg;
        out_removed_next = out_removed_reg;

        if (cmd.capture)
        begin
            func_next    = func;
            val_next     = value;
            idx_next     = '0;
            kept_next    = '0;
            removed_next = '0;
            code_next    = STAT_DONE;
        end

        if (cmd.exec)
        begin
            unique case (func_reg)
                FUNC_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        code_next = STAT_FULL;
                    end
                    else
                    begin
                        head_next  = head_dec;
                        we         = 1'b1;
                        waddr      = head_dec;
                        count_next = count_reg + 1'b1;
                    end
                end
                FUNC_PUSH_BACK:
                begin
                    if (full)
                    begin
                        code_next = STAT_FULL;
                    end
                    else
                    begin
                        we         = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                FUNC_POP_FRONT:
                begin
                    if (empty)
                    begin
                        code_next = STAT_EMPTY;
                    end
                    else
                    begin
                        head_next    = head_inc;
                        count_next   = count_reg - 1'b1;
                        removed_next = CW'(1);
                    end
                end
                FUNC_POP_BACK:
                begin
                    if (empty)
                    begin
                        code_next = STAT_EMPTY;
                    end
                    else
                    begin
                        count_next   = count_reg - 1'b1;
                        removed_next = CW'(1);
                    end
                end
                FUNC_CLEAR:
                begin
                    if (empty)
                    begin
                        code_next = STAT_EMPTY;
                    end
                    else
                    begin
                        removed_next = count_reg;
                        count_next   = '0;
                        head_next    = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // one walk step: keep a non-matching entry by moving it down to kept
        if (cmd.rm_write)
        begin
            idx_next = idx_inc;
            if (rd_a_reg != val_reg)
            begin
                we     = 1'b1;
                waddr  = slot(head_reg, kept_reg);
                wdata  = rd_a_reg;
                kept_n = kept_reg + 1'b1;
            end
            kept_next = kept_n;
            if (idx_inc == count_reg)
            begin
                count_next   = kept_n;
                removed_next = count_reg - kept_n;
            end
        end

        // result register load
        if (cmd.load)
        begin
            out_valid_next   = 1'b1;
            out_status_next  = code_reg;
            out_count_next   = count_reg;
            out_front_next   = empty ? '0 : rd_a_reg;
            out_back_next    = empty ? '0 : rd_b_reg;
            out_removed_next = removed_reg;
        end
    end

    // entry memory, one write and two registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        kept_reg        <= kept_next;
        func_reg        <= func_next;
        val_reg         <= val_next;
        code_reg        <= code_next;
        removed_reg     <= removed_next;
        out_status_reg  <= out_status_next;
        out_count_reg   <= out_count_next;
        out_front_reg   <= out_front_next;
        out_back_reg    <= out_back_next;
        out_removed_reg <= out_removed_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign entry_count   = out_count_reg;
    assign front_value   = out_front_reg;
    assign back_value    = out_back_reg;
    assign removed_count = out_removed_reg;

endmodule

FILE: src/dq_ctrl.sv
// dq_ctrl: sequencing state machine for the double-ended queue.
// Depends on dq_pkg; issues commands to dq_datapath.
module dq_ctrl
    import dq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output dq_cmd_t  cmd,
    input  dq_stat_t stat
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_RM_RD  = 6'b000100,
        S_RM_WR  = 6'b001000,
        S_LOOKUP = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // state transitions and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.is_remove && !stat.is_empty)
                begin
                    state_next = S_RM_RD;
                end
                else
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_RM_RD:
            begin
                cmd.rm_read = 1'b1;
                state_next  = S_RM_WR;
            end
            S_RM_WR:
            begin
                cmd.rm_write = 1'b1;
                state_next   = stat.walk_last ? S_LOOKUP : S_RM_RD;
            end
            S_LOOKUP:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/double_ended_queue.sv
// Double-ended queue of DEPTH signed 32-bit entries held in a ring buffer
// memory. One item is in flight at a time: push, pop, clear and unused codes
// pass through execute, memory lookup of front and back, and result load
// before result valid, and a new transfer in is taken only once the result
// is loaded; a remove-matching item adds a read and a write step per entry,
// since the walk reads and conditionally rewrites each entry through the
// single-write, registered-read memory. A new item is taken while the
// previous result still waits in the output register. The memory needs no
// clearing after reset; only held entries are ever reported.
// Depends on dq_pkg, dq_ctrl and dq_datapath.
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int CW = $clog2(DEPTH + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         func,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [CW-1:0]      entry_count,
    output logic signed [31:0] front_value,
    output logic signed [31:0] back_value,
    output logic [CW-1:0]      removed_count
);

    dq_cmd_t  cmd;
    dq_stat_t stat;

    // sequencing
    dq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // storage and result
    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .func          (func),
        .value         (value),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .status        (status),
        .entry_count   (entry_count),
        .front_value   (front_value),
        .back_value    (back_value),
        .removed_count (removed_count)
    );

endmodule

FILE: src/dq_checker.sv
// dq_checker: port-level assertions for double_ended_queue, attached by bind.
// Depends on dq_pkg.
module dq_checker
    import dq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int CW = $clog2(DEPTH + 1)
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         status,
    input logic [CW-1:0]      entry_count,
    input logic signed [31:0] front_value,
    input logic signed [31:0] back_value,
    input logic [CW-1:0]      removed_count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({status, entry_count, front_value, back_value, removed_count}))
        else $error("result changed while stalled");

    // one item in flight: ready drops after an input transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken twice in a row");

    // refused push, pop or clear deletes nothing
    a_refused: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_FULL || status == STAT_EMPTY) |-> removed_count == '0)
        else $error("refused item reports removals");

    // empty queue shows zero ends
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entry_count == '0 |-> front_value == '0 && back_value == '0)
        else $error("empty queue with nonzero front or back");

endmodule

bind double_ended_queue dq_checker #(
    .DEPTH (DEPTH)
) u_dq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .entry_count   (entry_count),
    .front_value   (front_value),
    .back_value    (back_value),
    .removed_count (removed_count)
);

FILE: tb/double_ended_queue_tb.sv
// double_ended_queue_tb: self-checking bench for the double-ended queue, with a
// cycle-free queue predictor, valid/ready driver and result monitor.
// Depends on dq_pkg and double_ended_queue.
`timescale 1ns / 1ps

module double_ended_queue_tb
    import dq_pkg::*;
();

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    // func codes the block treats as no-ops
    localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

    localparam int RESET_CYCLES = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 200;
    localparam int QUIET_LIMIT = 5000;
    localparam int PHASE_ITEMS = 450;
    localparam int REPORT_MAX = 10;
    localparam int OP_CAP = 4096;
    localparam int OP_AW = 12;

    typedef enum logic [1:0] {
        PROF_TX30_RX68,
        PROF_TX68_RX30,
        PROF_NO_IDLE
    } idle_profile_t;

    // one queued operation for the driver
    typedef struct {
        logic [2:0]    func;
        logic [31:0]   value;
        idle_profile_t profile;
        bit            drain;
        bit            hold;
    } deque_op_t;

    // queue state reported after one operation
    typedef struct packed {
        logic [2:0]    func;
        logic [31:0]   value;
        logic [1:0]    status;
        logic [CW-1:0] count;
        logic [31:0]   front;
        logic [31:0]   back;
        logic [CW-1:0] removed;
    } deque_view_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         func = FUNC_PUSH_FRONT;
    logic signed [31:0] value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status;
    logic [CW-1:0]      entry_count;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [CW-1:0]      removed_count;

    double_ended_queue #(.DEPTH(DEPTH)) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .entry_count   (entry_count),
        .front_value   (front_value),
        .back_value    (back_value),
        .removed_count (removed_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // pending operations and expected views, each with write and read counts
    deque_op_t     op_store[OP_CAP];
    int unsigned   op_wr = 0;
    int unsigned   op_rd = 0;
    deque_view_t   view_store[OP_CAP];
    int unsigned   view_wr = 0;
    int unsigned   view_rd = 0;
    idle_profile_t rx_profile = PROF_TX30_RX68;
    logic          hold_kick = 1'b0;
    int unsigned   items_taken = 0;
    int unsigned   results_taken = 0;
    int unsigned   fail_count = 0;
    int unsigned   rx_hold_left = 0;
    int unsigned   quiet_cycles = 0;

    // predictor state: ring buffer, front index, fill level
    logic [31:0]   model_ring[DEPTH];
    int unsigned   model_head = 0;
    int unsigned   model_fill = 0;

    // stimulus generator settings
    idle_profile_t gen_profile = PROF_TX30_RX68;
    bit            gen_drain_next = 1'b0;
    bit            gen_hold_next = 1'b0;
    logic [31:0]   value_pool[8];

    // apply one operation to the predicted queue and report its view
    function automatic deque_view_t deque_model_step(input logic [2:0] f, input logic [31:0] v);
        deque_view_t r;
        int unsigned kept;
        logic [31:0] e;
        r = '0;
        r.func = f;
        r.value = v;
        r.status = STAT_DONE;
        case (f)
            FUNC_PUSH_FRONT:
                if (model_fill >= DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    model_head = (model_head + DEPTH - 1) % DEPTH;
                    model_ring[AW'(model_head)] = v;
                    model_fill++;
                end
            FUNC_PUSH_BACK:
                if (model_fill >= DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    model_ring[AW'((model_head + model_fill) % DEPTH)] = v;
                    model_fill++;
                end
            FUNC_POP_FRONT:
                if (model_fill == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    model_head = (model_head + 1) % DEPTH;
                    model_fill--;
                    r.removed = CW'(1);
                end
            FUNC_POP_BACK:
                if (model_fill == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    model_fill--;
                    r.removed = CW'(1);
                end
            FUNC_REMOVE:
            begin
                // compact survivors toward the front, keeping order
                kept = 0;
                for (int i = 0; i < model_fill; i++)
                begin
                    e = model_ring[AW'((model_head + i) % DEPTH)];
                    if (e != v)
                    begin
                        model_ring[AW'((model_head + kept) % DEPTH)] = e;
                        kept++;
                    end
                end
                r.removed = CW'(model_fill - kept);
                model_fill = kept;
            end
            FUNC_CLEAR:
                if (model_fill == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    r.removed = CW'(model_fill);
                    model_fill = 0;
                    model_head = 0;
                end
            default:
                ;
        endcase
        r.count = CW'(model_fill);
        if (model_fill != 0)
        begin
            r.front = model_ring[AW'(model_head)];
            r.back = model_ring[AW'((model_head + model_fill - 1) % DEPTH)];
        end
        return r;
    endfunction

    function automatic bit tx_idles(input idle_profile_t p);
        case (p)
            PROF_TX30_RX68: return $urandom_range(99) < 30;
            PROF_TX68_RX30: return $urandom_range(99) < 68;
            default:        return 1'b0;
        endcase
    endfunction

    function automatic bit rx_idles(input idle_profile_t p);
        case (p)
            PROF_TX30_RX68: return $urandom_range(99) < 68;
            PROF_TX68_RX30: return $urandom_range(99) < 30;
            default:        return 1'b0;
        endcase
    endfunction

    task automatic queue_op(input logic [2:0] f, input logic [31:0] v);
        deque_op_t op;
        op.func = f;
        op.value = v;
        op.profile = gen_profile;
        op.drain = gen_drain_next;
        op.hold = gen_hold_next;
        gen_drain_next = 1'b0;
        gen_hold_next = 1'b0;
        op_store[OP_AW'(op_wr)] = op;
        op_wr++;
    endtask

    // mostly recurring values so removals find matches
    function automatic logic [31:0] pick_value();
        if ($urandom_range(99) < 60)
            return value_pool[3'($urandom_range(7))];
        return $urandom;
    endfunction

    // driver: offers queued operations, predicts each accepted transfer
    always @(posedge clk)
    begin : op_driver
        deque_op_t nxt;
        logic      fire;
        logic      offer;
        logic      kick;
        if (rst_n)
        begin
            fire = in_valid && in_ready;
            offer = 1'b0;
            kick = 1'b0;
            if (fire)
            begin
                view_store[OP_AW'(view_wr)] = deque_model_step(func, value);
                view_wr++;
                items_taken <= items_taken + 1;
            end
            if (!in_valid || fire)
            begin
                if (op_rd != op_wr)
                begin
                    nxt = op_store[OP_AW'(op_rd)];
                    // a drain point waits until every result is back
                    if (!(nxt.drain && (fire || items_taken != results_taken))
                        && !tx_idles(nxt.profile))
                    begin
                        op_rd++;
                        offer = 1'b1;
                        kick = nxt.hold;
                        func <= nxt.func;
                        value <= nxt.value;
                        rx_profile <= nxt.profile;
                    end
                end
                in_valid <= offer;
            end
            hold_kick <= kick;
        end
    end

    // monitor: checks each result transfer against the oldest prediction
    always @(posedge clk)
    begin : result_monitor
        deque_view_t want;
        logic        rdy;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_taken <= results_taken + 1;
                if (view_rd == view_wr)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("unexpected result: status %0d count %0d front %h back %h removed %0d",
                                 status, entry_count, front_value, back_value, removed_count);
                end
                else
                begin
                    want = view_store[OP_AW'(view_rd)];
                    view_rd++;
                    if (status !== want.status || entry_count !== want.count
                        || front_value !== want.front || back_value !== want.back
                        || removed_count !== want.removed)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                        begin
                            $display("mismatch for func %0d value %h:", want.func, want.value);
                            $display("  expected status %0d count %0d front %h back %h removed %0d",
                                     want.status, want.count, want.front, want.back,
                                     want.removed);
                            $display("  actual   status %0d count %0d front %h back %h removed %0d",
                                     status, entry_count, front_value, back_value,
                                     removed_count);
                        end
                    end
                end
            end
            // long hold-off requested by the driver, else random idling
            if (hold_kick)
                rx_hold_left = HOLD_CYCLES;
            if (rx_hold_left != 0)
            begin
                rx_hold_left--;
                rdy = 1'b0;
            end
            else
                rdy = !rx_idles(rx_profile);
            out_ready <= rdy;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("double_ended_queue_tb: FAIL");
                    $finish;
                end
            end
        end
    end

    initial
    begin : stimulus
        int unsigned pick;
        int unsigned n;
        int unsigned start_size;
        bit          hold_done;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h7FFF_FFFF;
        for (int i = 4; i < 8; i++)
            value_pool[3'(i)] = $urandom;

        // empty-queue cases and no-op codes
        queue_op(FUNC_POP_FRONT, 32'h0);
        queue_op(FUNC_POP_BACK, 32'h0);
        queue_op(FUNC_CLEAR, 32'h0);
        queue_op(FUNC_REMOVE, 32'h0);
        queue_op(FUNC_SPARE_6, 32'hFFFF_FFFF);
        queue_op(FUNC_SPARE_7, 32'h0);
        // single-entry pops and clear
        queue_op(FUNC_PUSH_FRONT, 32'h5);
        queue_op(FUNC_POP_FRONT, 32'h0);
        queue_op(FUNC_PUSH_BACK, 32'h7);
        queue_op(FUNC_POP_BACK, 32'h0);
        queue_op(FUNC_PUSH_BACK, 32'h1234_5678);
        queue_op(FUNC_CLEAR, 32'h0);
        // extreme values, removal at the head, no-match removal
        queue_op(FUNC_PUSH_FRONT, 32'h7FFF_FFFF);
        queue_op(FUNC_PUSH_BACK, 32'h8000_0000);
        queue_op(FUNC_PUSH_FRONT, 32'h8000_0000);
        queue_op(FUNC_PUSH_BACK, 32'hFFFF_FFFF);
        queue_op(FUNC_PUSH_BACK, 32'h0);
        queue_op(FUNC_SPARE_6, 32'hA5A5_5A5A);
        queue_op(FUNC_REMOVE, 32'h8000_0000);
        queue_op(FUNC_REMOVE, 32'h55);
        queue_op(FUNC_PUSH_FRONT, 32'hFFFF_FFFF);
        queue_op(FUNC_REMOVE, 32'hFFFF_FFFF);
        queue_op(FUNC_POP_BACK, 32'h0);
        queue_op(FUNC_POP_FRONT, 32'h0);
        // removal that empties the queue
        queue_op(FUNC_PUSH_BACK, 32'h9);
        queue_op(FUNC_PUSH_FRONT, 32'h9);
        queue_op(FUNC_REMOVE, 32'h9);

        // random episodes, one idle profile per phase
        for (int p = 0; p < 3; p++)
        begin
            gen_profile = idle_profile_t'(p);
            gen_drain_next = 1'b1;
            start_size = op_wr;
            hold_done = 1'b0;
            while (op_wr - start_size < PHASE_ITEMS)
            begin
                if (p != 1 && !hold_done && op_wr - start_size >= 40)
                begin
                    gen_hold_next = 1'b1;
                    hold_done = 1'b1;
                end
                pick = $urandom_range(99);
                if (pick < 25)
                begin
                    // fill burst, often reaching full
                    n = $urandom_range(20, 70);
                    repeat (n)
                        queue_op($urandom_range(1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT,
                                 pick_value());
                end
                else if (pick < 45)
                begin
                    n = $urandom_range(5, 70);
                    repeat (n)
                        queue_op($urandom_range(1) ? FUNC_POP_BACK : FUNC_POP_FRONT,
                                 $urandom);
                end
                else if (pick < 60)
                    queue_op(FUNC_REMOVE, pick_value());
                else if (pick < 65)
                    queue_op(FUNC_CLEAR, $urandom);
                else
                begin
                    // mixed noise including the spare codes
                    n = $urandom_range(5, 30);
                    repeat (n)
                        queue_op(3'($urandom_range(7)), pick_value());
                end
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // wait for all transfers, then let the block settle
        do
            @(posedge clk);
        while (op_rd != op_wr || in_valid || items_taken != results_taken);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0 && view_rd == view_wr)
            $display("double_ended_queue_tb: PASS");
        else
            $display("double_ended_queue_tb: FAIL");
        $finish;
    end

endmodule
